// ----- hw/rtl/ppse_pkg.sv -----
// Shared types, constants and helpers for the spline evaluator.
// Used by ppse_front, ppse_back and piecewise_polynomial_spline_eval.
package ppse_pkg;

  localparam int MAX_SEGMENTS_DEF      = 16;
  localparam int COEFS_PER_SEGMENT_DEF = 8;
  localparam int FRAC_BITS_DEF         = 16;

  // Queued operation after classification
  typedef enum logic [1:0] {
    OP_BOUNDS = 2'd0,
    OP_COEF   = 2'd1,
    OP_EVAL   = 2'd2
  } op_t;

  // Raw request codes on req_type
  localparam logic [1:0] REQ_BOUNDS = 2'd0;
  localparam logic [1:0] REQ_COEF   = 2'd1;
  localparam logic [1:0] REQ_EVAL   = 2'd2;

  // One queued item
  typedef struct packed {
    op_t                op;
    logic [3:0]         segment_index;
    logic [2:0]         coef_index;
    logic signed [31:0] lower_bound;
    logic signed [31:0] upper_bound;
    logic signed [31:0] coef_value;
    logic signed [31:0] query_time;
    logic [1:0]         deriv_order;
    logic               wrap_mode;
  } item_t;

  // Falling factorial power*(power-1)*...; order is at most three
  function automatic logic [15:0] falling(input logic [4:0] power, input logic [1:0] order);
    logic [15:0] f;
    f = 16'd1;
    for (int j = 0; j < 3; j++) begin
      if (j < int'(order)) begin
        f = 16'(f * 16'(power - 5'(j)));
      end
    end
    return f;
  endfunction

endpackage

// ----- hw/rtl/ppse_front.sv -----
// Front end: accepts items, classifies them and drops invalid loads and unknown requests.
// Holds a two-entry queue toward ppse_back. Depends on ppse_pkg.
module ppse_front #(
  parameter int MAX_SEGMENTS      = ppse_pkg::MAX_SEGMENTS_DEF,
  parameter int COEFS_PER_SEGMENT = ppse_pkg::COEFS_PER_SEGMENT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          req_type,
  input  logic [3:0]          segment_index,
  input  logic [2:0]          coef_index,
  input  logic signed [31:0]  lower_bound,
  input  logic signed [31:0]  upper_bound,
  input  logic signed [31:0]  coef_value,
  input  logic signed [31:0]  query_time,
  input  logic [1:0]          deriv_order,
  input  logic                wrap_mode,
  output logic                head_valid,
  output ppse_pkg::item_t     head_item,
  input  logic                pop
);

  ppse_pkg::item_t q [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            keep;
  logic            push;
  ppse_pkg::op_t   op;

  // Classify: loads out of range and unknown requests carry no work
  always_comb begin
    op   = ppse_pkg::OP_EVAL;
    keep = 1'b0;
    unique case (req_type)
      ppse_pkg::REQ_BOUNDS: begin
        op   = ppse_pkg::OP_BOUNDS;
        keep = 32'(segment_index) < MAX_SEGMENTS;
      end
      ppse_pkg::REQ_COEF: begin
        op   = ppse_pkg::OP_COEF;
        keep = (32'(segment_index) < MAX_SEGMENTS) && (32'(coef_index) < COEFS_PER_SEGMENT);
      end
      ppse_pkg::REQ_EVAL: begin
        op   = ppse_pkg::OP_EVAL;
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign busy       = (count == 2'd2);
  assign push       = start && !busy && keep;
  assign head_valid = (count != 2'd0);
  assign head_item  = q[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{op: op, segment_index: segment_index, coef_index: coef_index,
                     lower_bound: lower_bound, upper_bound: upper_bound,
                     coef_value: coef_value, query_time: query_time,
                     deriv_order: deriv_order, wrap_mode: wrap_mode};
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= 2'(count + {1'b0, push} - {1'b0, pop});
    end
  end

endmodule

// ----- hw/rtl/ppse_back.sv -----
// Back end: segment tables, binary search and Horner evaluation.
// Takes items from ppse_front. Depends on ppse_pkg.
module ppse_back #(
  parameter int MAX_SEGMENTS      = ppse_pkg::MAX_SEGMENTS_DEF,
  parameter int COEFS_PER_SEGMENT = ppse_pkg::COEFS_PER_SEGMENT_DEF,
  parameter int FRAC_BITS         = ppse_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [4:0]          segment_count,
  input  logic                head_valid,
  input  ppse_pkg::item_t     head_item,
  output logic                pop,
  output logic                result_valid,
  output logic signed [31:0]  result_value,
  output logic                saturated,
  output logic                table_empty
);

  localparam int SEG_AW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);
  localparam int CI_W    = $clog2(COEFS_PER_SEGMENT);
  localparam int COEF_N  = MAX_SEGMENTS * COEFS_PER_SEGMENT;
  localparam int COEF_AW = $clog2(COEF_N);

  typedef enum logic [3:0] {
    S_IDLE, S_CLAMP_RD, S_CLAMP, S_SRCH, S_CMP, S_OFS_RD, S_OFS,
    S_H_RD, S_H_MUL, S_H_ADD
  } state_t;

  state_t                  state;
  logic signed [31:0]      start_mem [MAX_SEGMENTS];
  logic signed [31:0]      end_mem   [MAX_SEGMENTS];
  logic signed [31:0]      coef_mem  [COEF_N];
  logic signed [31:0]      start_rd, end_rd, coef_rd;
  logic [SEG_AW-1:0]       start_addr, end_addr;
  logic [COEF_AW-1:0]      coef_addr;

  logic [CNT_W-1:0]        n_eff;
  logic signed [CNT_W:0]   low, up;
  logic [CNT_W-1:0]        mid;
  logic [CNT_W:0]          mid_sum;
  logic [SEG_AW-1:0]       idx;
  logic signed [32:0]      x;
  logic signed [32:0]      x_wrap;
  logic signed [32:0]      neg_q;
  logic signed [32:0]      d;
  logic [1:0]              order;
  logic [CI_W-1:0]         ci;
  logic signed [31:0]      acc;
  logic signed [64:0]      prod;
  logic signed [48:0]      term;
  logic signed [65:0]      sum;
  logic signed [31:0]      sum_sat;
  logic                    sum_clip;
  logic                    sat_acc;
  logic signed [CNT_W:0]   last_ptr;

  localparam logic signed [32:0] ONE_FX   = 33'sd1 <<< FRAC_BITS;
  localparam logic signed [32:0] FRAC_MSK = ONE_FX - 33'sd1;

  // Active segment count, capped at the table depth
  always_comb begin
    if (int'(segment_count) > MAX_SEGMENTS) n_eff = CNT_W'(MAX_SEGMENTS);
    else                                     n_eff = CNT_W'(segment_count);
  end

  assign last_ptr = (CNT_W+1)'($signed({1'b0, n_eff}) - 1);
  assign pop      = (state == S_IDLE) && head_valid;

  // Optional wrap of the query time into zero to one
  always_comb begin
    x_wrap = 33'(head_item.query_time);
    neg_q  = -x_wrap;
    if (head_item.wrap_mode) begin
      if (x_wrap < 0)           x_wrap = ONE_FX - (neg_q & FRAC_MSK);
      else if (x_wrap > ONE_FX) x_wrap = x_wrap & FRAC_MSK;
    end
  end

  // Search midpoint
  assign mid_sum = $unsigned(low) + $unsigned(up);
  assign mid     = mid_sum[CNT_W:1];

  // Read addresses by state
  always_comb begin
    start_addr = idx;
    end_addr   = SEG_AW'(last_ptr);
    coef_addr  = COEF_AW'(int'(idx) * COEFS_PER_SEGMENT + int'(ci));
    unique case (state)
      S_CLAMP_RD: start_addr = '0;
      S_SRCH: begin
        start_addr = SEG_AW'(mid);
        end_addr   = SEG_AW'(mid);
      end
      default: ;
    endcase
  end

  // Horner add and saturate
  always_comb begin
    sum      = 66'(prod >>> FRAC_BITS) + 66'(term);
    sum_clip = 1'b1;
    if (sum > 66'sd2147483647)       sum_sat = 32'sh7fffffff;
    else if (sum < -66'sd2147483648) sum_sat = 32'sh80000000;
    else begin
      sum_sat  = sum[31:0];
      sum_clip = 1'b0;
    end
  end

  // Tables: written by loads, read with registered data
  always_ff @(posedge clk) begin
    if (pop && head_item.op == ppse_pkg::OP_BOUNDS) begin
      start_mem[SEG_AW'(head_item.segment_index)] <= head_item.lower_bound;
      end_mem[SEG_AW'(head_item.segment_index)]   <= head_item.upper_bound;
    end
    if (pop && head_item.op == ppse_pkg::OP_COEF) begin
      coef_mem[COEF_AW'(int'(head_item.segment_index) * COEFS_PER_SEGMENT
                        + int'(head_item.coef_index))] <= head_item.coef_value;
    end
    start_rd <= start_mem[start_addr];
    end_rd   <= end_mem[end_addr];
    coef_rd  <= coef_mem[coef_addr];
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (pop && head_item.op == ppse_pkg::OP_EVAL) begin
            order   <= head_item.deriv_order;
            x       <= x_wrap;
            sat_acc <= 1'b0;
            if (n_eff == '0) begin
              result_valid <= 1'b1;
              result_value <= '0;
              saturated    <= 1'b0;
              table_empty  <= 1'b1;
            end else begin
              state <= S_CLAMP_RD;
            end
          end
        end
        S_CLAMP_RD: state <= S_CLAMP;
        S_CLAMP: begin
          // clamp to the first start, then to the last end
          if (x <= 33'(start_rd)) begin
            if (start_rd >= end_rd) x <= 33'(end_rd);
            else                    x <= 33'(start_rd);
          end else if (x >= 33'(end_rd)) begin
            x <= 33'(end_rd);
          end
          low   <= '0;
          up    <= last_ptr;
          state <= S_SRCH;
        end
        S_SRCH: begin
          if (low < up) begin
            state <= S_CMP;
          end else begin
            if (low > last_ptr) idx <= SEG_AW'(last_ptr);
            else                idx <= SEG_AW'(low);
            state <= S_OFS_RD;
          end
        end
        S_CMP: begin
          if (x < 33'(start_rd)) begin
            up <= (CNT_W+1)'($signed({1'b0, mid}) - 1);
          end else if (x > 33'(end_rd)) begin
            low <= (CNT_W+1)'($signed({1'b0, mid}) + 1);
          end else begin
            low <= $signed({1'b0, mid});
            up  <= $signed({1'b0, mid});
          end
          state <= S_SRCH;
        end
        S_OFS_RD: begin
          ci    <= CI_W'(COEFS_PER_SEGMENT - 1);
          state <= S_OFS;
        end
        S_OFS: begin
          d   <= x - 33'(start_rd);
          acc <= '0;
          if (int'(order) >= COEFS_PER_SEGMENT) begin
            result_valid <= 1'b1;
            result_value <= '0;
            saturated    <= 1'b0;
            table_empty  <= 1'b0;
            state        <= S_IDLE;
          end else begin
            state <= S_H_RD;
          end
        end
        S_H_RD: state <= S_H_MUL;
        S_H_MUL: begin
          prod  <= acc * d;
          term  <= coef_rd * $signed({1'b0, ppse_pkg::falling(5'(ci), order)});
          state <= S_H_ADD;
        end
        S_H_ADD: begin
          acc <= sum_sat;
          if (int'(ci) == int'(order)) begin
            result_valid <= 1'b1;
            result_value <= sum_sat;
            saturated    <= sat_acc | sum_clip;
            table_empty  <= 1'b0;
            state        <= S_IDLE;
          end else begin
            sat_acc <= sat_acc | sum_clip;
            ci      <= ci - 1'b1;
            state   <= S_H_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/piecewise_polynomial_spline_eval.sv -----
// Piecewise polynomial spline evaluator, top level.
// Instantiates ppse_front and ppse_back; depends on ppse_pkg.
//
// Usage:
//   Items enter on start while busy is low: req_type 0 loads a segment's
//   bounds, 1 loads one coefficient, 2 evaluates at query_time.
//   cfg_we/cfg_data write segment_count (write only while idle).
//   An evaluate item yields one result, shown for one cycle with
//   result_valid; loads and unknown requests yield nothing.
// Flow:
//   Items pass a two-entry queue; busy rises when it is full.
//   An evaluation runs on one sequencer: it takes and clamps the query
//   (S_CLAMP_RD, S_CLAMP), searches (S_SRCH, S_CMP per step; at most 4 steps
//   for 16 segments), forms the offset (S_OFS_RD, S_OFS), then runs Horner steps
//   (S_H_RD, S_H_MUL, S_H_ADD; COEFS_PER_SEGMENT - deriv_order steps).
//   A load is written to the table as it leaves the queue. No item leaves
//   the queue while an evaluation runs. An empty table answers in the cycle
//   after the item leaves the queue.
// Reset: clears the queue, sequencer and segment_count; tables keep
//   their contents and are undefined until loaded.
// The receiver cannot stall; results are taken when shown.
module piecewise_polynomial_spline_eval #(
  parameter int MAX_SEGMENTS      = ppse_pkg::MAX_SEGMENTS_DEF,
  parameter int COEFS_PER_SEGMENT = ppse_pkg::COEFS_PER_SEGMENT_DEF,
  parameter int FRAC_BITS         = ppse_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_data,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type,
  input  logic [3:0]         segment_index,
  input  logic [2:0]         coef_index,
  input  logic signed [31:0] lower_bound,
  input  logic signed [31:0] upper_bound,
  input  logic signed [31:0] coef_value,
  input  logic signed [31:0] query_time,
  input  logic [1:0]         deriv_order,
  input  logic               wrap_mode,
  output logic               result_valid,
  output logic signed [31:0] result_value,
  output logic               saturated,
  output logic               table_empty
);

  logic            [4:0] segment_count;
  logic                  head_valid;
  logic                  pop;
  ppse_pkg::item_t       head_item;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      segment_count <= '0;
    end else if (cfg_we) begin
      segment_count <= cfg_data;
    end
  end

  ppse_front #(
    .MAX_SEGMENTS(MAX_SEGMENTS),
    .COEFS_PER_SEGMENT(COEFS_PER_SEGMENT)
  ) u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .segment_index(segment_index), .coef_index(coef_index),
    .lower_bound(lower_bound), .upper_bound(upper_bound), .coef_value(coef_value),
    .query_time(query_time), .deriv_order(deriv_order), .wrap_mode(wrap_mode),
    .head_valid(head_valid), .head_item(head_item), .pop(pop)
  );

  ppse_back #(
    .MAX_SEGMENTS(MAX_SEGMENTS),
    .COEFS_PER_SEGMENT(COEFS_PER_SEGMENT),
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk(clk), .rst(rst), .segment_count(segment_count),
    .head_valid(head_valid), .head_item(head_item), .pop(pop),
    .result_valid(result_valid), .result_value(result_value),
    .saturated(saturated), .table_empty(table_empty)
  );

endmodule

// ----- tb/sv/tb_piecewise_polynomial_spline_eval.sv -----
// Self-checking testbench for piecewise_polynomial_spline_eval.
// Depends on ppse_pkg and the RTL; predicts every evaluate result in Q16.16
// and checks the result stream against it under random start and idle gaps.
`timescale 1ns / 1ps

module tb_piecewise_polynomial_spline_eval;

  localparam logic [1:0] REQ_NONE = 2'd3;   // unused code, ignored by the block
  localparam int NSEG = ppse_pkg::MAX_SEGMENTS_DEF;
  localparam int NCOEF = ppse_pkg::COEFS_PER_SEGMENT_DEF;
  localparam int FRAC = ppse_pkg::FRAC_BITS_DEF;
  localparam longint ONE_Q = longint'(1) << FRAC;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam int SEG_STEP = 32'h4000;       // 0.25 per segment in the tidy table
  localparam int SETTLE = 120;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [1:0]  req;
    logic [3:0]  seg;
    logic [2:0]  ci;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] coef;
    logic [31:0] qt;
    logic [1:0]  order;
    logic        wrap;
  } spline_item_t;

  typedef struct {
    logic [31:0] value;
    logic        sat;
    logic        empty;
  } spline_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [4:0] cfg_data = '0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] req_type = '0;
  logic [3:0] segment_index = '0;
  logic [2:0] coef_index = '0;
  logic signed [31:0] lower_bound = '0;
  logic signed [31:0] upper_bound = '0;
  logic signed [31:0] coef_value = '0;
  logic signed [31:0] query_time = '0;
  logic [1:0] deriv_order = '0;
  logic wrap_mode = 1'b0;
  logic result_valid;
  logic signed [31:0] result_value;
  logic saturated;
  logic table_empty;

  piecewise_polynomial_spline_eval u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .start(start), .busy(busy), .req_type(req_type),
    .segment_index(segment_index), .coef_index(coef_index),
    .lower_bound(lower_bound), .upper_bound(upper_bound),
    .coef_value(coef_value), .query_time(query_time),
    .deriv_order(deriv_order), .wrap_mode(wrap_mode),
    .result_valid(result_valid), .result_value(result_value),
    .saturated(saturated), .table_empty(table_empty)
  );

  always #10 clk = ~clk;

  // Shadow of the block's table and register
  longint seg_lo [NSEG];
  longint seg_hi [NSEG];
  longint coefs [NSEG*NCOEF];
  int seg_count_shadow = 0;

  spline_item_t pending_items[$];
  spline_result_t expected_results[$];
  int errors = 0;
  int cycles = 0;
  logic took = 1'b0;
  int gap = 0;
  bit steady = 0;   // no gaps at all while set

  function automatic longint sx(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint falling_fact(int power, int order);
    longint f;
    f = 1;
    for (int j = 0; j < order; j++) f = f * (power - j);
    return f;
  endfunction

  // Spline value or derivative for one evaluate item
  function automatic spline_result_t spline_eval(spline_item_t it);
    spline_result_t r;
    int n, lo_i, up_i, mid, idx, order;
    longint x, d, acc, term;
    logic signed [127:0] prod;
    bit sat;
    n = seg_count_shadow > NSEG ? NSEG : seg_count_shadow;
    r.value = '0; r.sat = 1'b0; r.empty = 1'b0;
    if (n == 0) begin
      r.empty = 1'b1;
      return r;
    end
    order = int'(it.order);
    x = sx(it.qt);
    if (it.wrap) begin
      if (x < 0) x = ONE_Q - ((-x) & (ONE_Q - 1));
      else if (x > ONE_Q) x = x & (ONE_Q - 1);
    end
    if (x <= seg_lo[0]) x = seg_lo[0];
    if (x >= seg_hi[n-1]) x = seg_hi[n-1];
    // binary search; crossed pointers fall back to the clamped low pointer
    lo_i = 0; up_i = n - 1;
    while (lo_i < up_i) begin
      mid = (lo_i + up_i) / 2;
      if (x < seg_lo[mid]) up_i = mid - 1;
      else if (x > seg_hi[mid]) lo_i = mid + 1;
      else begin lo_i = mid; up_i = mid; end
    end
    idx = lo_i < 0 ? 0 : (lo_i > n - 1 ? n - 1 : lo_i);
    d = x - seg_lo[idx];
    acc = 0; sat = 0;
    // Horner, floor shift after each exact multiply, saturate each step
    for (int i = NCOEF - 1; i >= order; i--) begin
      term = coefs[idx*NCOEF + i] * falling_fact(i, order);
      prod = (128'(signed'(acc)) * 128'(signed'(d))) >>> FRAC;
      prod = prod + 128'(signed'(term));
      if (prod > 128'(signed'(S32_MAX))) begin acc = S32_MAX; sat = 1; end
      else if (prod < 128'(signed'(S32_MIN))) begin acc = S32_MIN; sat = 1; end
      else acc = longint'(prod);
    end
    r.value = acc[31:0];
    r.sat = sat;
    return r;
  endfunction

  // Apply one accepted item to the shadow table
  task automatic spline_accept(spline_item_t it);
    case (it.req)
      ppse_pkg::REQ_BOUNDS: begin
        seg_lo[it.seg] = sx(it.lo);
        seg_hi[it.seg] = sx(it.hi);
      end
      ppse_pkg::REQ_COEF: coefs[it.seg*NCOEF + it.ci] = sx(it.coef);
      ppse_pkg::REQ_EVAL: expected_results.insert(expected_results.size(), spline_eval(it));
      default: ;
    endcase
  endtask

  // Acceptance and result checking at the rising edge
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (!rst) begin
      took <= start && !busy;
      if (start && !busy) spline_accept(pending_items[0]);
      if (result_valid) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result value=%h sat=%b empty=%b",
                   $time, result_value, saturated, table_empty);
          errors++;
        end else begin
          spline_result_t e;
          e = expected_results.pop_front();
          if (e.value !== result_value || e.sat !== saturated || e.empty !== table_empty) begin
            $display("%0t: mismatch exp value=%h sat=%b empty=%b act value=%h sat=%b empty=%b",
                     $time, e.value, e.sat, e.empty, result_value, saturated, table_empty);
            errors++;
          end
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver: presents the head item; the accepted one leaves the queue
  always @(negedge clk) begin
    if (!rst) begin
      if (start && took) void'(pending_items.pop_front());
      if (!start || took) begin
        if (gap > 0) begin
          gap--;
          start <= 1'b0;
        end else if (pending_items.size() > 0) begin
          req_type <= pending_items[0].req;
          segment_index <= pending_items[0].seg;
          coef_index <= pending_items[0].ci;
          lower_bound <= pending_items[0].lo;
          upper_bound <= pending_items[0].hi;
          coef_value <= pending_items[0].coef;
          query_time <= pending_items[0].qt;
          deriv_order <= pending_items[0].order;
          wrap_mode <= pending_items[0].wrap;
          start <= 1'b1;
          gap = pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  function automatic spline_item_t blank_item(logic [1:0] req);
    spline_item_t it;
    it.req = req; it.seg = 4'($urandom); it.ci = 3'($urandom);
    it.lo = $urandom; it.hi = $urandom; it.coef = $urandom; it.qt = $urandom;
    it.order = 2'($urandom); it.wrap = 1'($urandom);
    return it;
  endfunction

  task automatic push_bounds(int s, logic [31:0] lo, logic [31:0] hi);
    spline_item_t it;
    it = blank_item(ppse_pkg::REQ_BOUNDS);
    it.seg = 4'(s); it.lo = lo; it.hi = hi;
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic push_coef(int s, int c, logic [31:0] v);
    spline_item_t it;
    it = blank_item(ppse_pkg::REQ_COEF);
    it.seg = 4'(s); it.ci = 3'(c); it.coef = v;
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic push_eval(logic [31:0] q, logic [1:0] order, logic wrap);
    spline_item_t it;
    it = blank_item(ppse_pkg::REQ_EVAL);
    it.qt = q; it.order = order; it.wrap = wrap;
    pending_items.insert(pending_items.size(), it);
  endtask

  function automatic logic [31:0] rand_coef();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF);
    if (r < 8) return 32'($signed($urandom_range(0, 32'hFFF)) - 32'sh7FF);
    return $urandom;
  endfunction

  function automatic logic [31:0] rand_query();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 32'($urandom_range(0, 16*SEG_STEP + 32'h2000)) - 32'h1000;
    if (r < 7) return 32'($signed($urandom_range(0, 32'h40000)) - 32'sh20000);
    return $urandom;
  endfunction

  task automatic wait_idle();
    while (pending_items.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_count(logic [4:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    seg_count_shadow = int'(v);
  endtask

  // One random phase: mostly tidy reloads and evaluates, some noise
  task automatic random_phase(int items);
    int r, s;
    for (int k = 0; k < items; k++) begin
      r = $urandom_range(0, 99);
      s = $urandom_range(0, NSEG - 1);
      if (r < 60) push_eval(rand_query(), 2'($urandom), 1'($urandom));
      else if (r < 78) push_coef(s, $urandom_range(0, NCOEF - 1), rand_coef());
      else if (r < 90)
        push_bounds(s, s*SEG_STEP + $urandom_range(0, 16) - 8,
                    (s+1)*SEG_STEP + $urandom_range(0, 16) - 8);
      else if (r < 95) push_bounds(s, $urandom, $urandom);
      else pending_items.insert(pending_items.size(), blank_item(REQ_NONE));
    end
  endtask

  initial begin
    logic [4:0] counts [10] = '{5'd1, 5'd16, 5'd2, 5'd31, 5'd5, 5'd8, 5'd17, 5'd3, 5'd12, 5'd16};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty table, ignored request code
    write_count(5'd0);
    push_eval(32'h8000_0000, 2'd0, 1'b0);
    push_eval(32'h7FFF_FFFF, 2'd3, 1'b1);
    pending_items.insert(pending_items.size(), blank_item(REQ_NONE));
    push_eval(32'h0, 2'd1, 1'b0);
    // tidy table over 0..4.0 with every coefficient written
    for (int s = 0; s < NSEG; s++) begin
      push_bounds(s, s*SEG_STEP, (s+1)*SEG_STEP);
      for (int c = 0; c < NCOEF; c++) push_coef(s, c, rand_coef());
    end
    push_eval(32'h1000, 2'd2, 1'b0);
    wait_idle();

    // extremes of the query, wrapping, every derivative order
    write_count(5'd16);
    push_eval(32'h8000_0000, 2'd0, 1'b0);
    push_eval(32'h7FFF_FFFF, 2'd1, 1'b0);
    push_eval(32'hFFFF_C000, 2'd2, 1'b1);   // -0.25 wraps to 0.75
    push_eval(32'hFFFF_0000, 2'd3, 1'b1);   // -1.0 wraps to 1.0
    push_eval(32'h0002_0000, 2'd0, 1'b1);   // 2.0 wraps to 0.0
    push_eval(32'h0001_0000, 2'd1, 1'b1);   // 1.0 stays
    push_eval(32'h0002_0000, 2'd2, 1'b0);
    push_eval(32'h0004_0000, 2'd3, 1'b0);   // span end
    // force clipping in the first segment
    push_coef(0, 7, 32'h7FFF_FFFF);
    push_coef(0, 0, 32'h8000_0000);
    push_eval(32'h0000_3000, 2'd0, 1'b0);
    push_eval(32'h0000_3000, 2'd1, 1'b0);
    push_coef(0, 7, 32'h0000_0100);
    push_coef(0, 0, 32'h0001_0000);
    push_eval(32'h0000_2000, 2'd0, 1'b0);
    wait_idle();

    for (int p = 0; p < 10; p++) begin
      write_count(counts[p]);
      steady = (p % 4 == 3);
      random_phase(85);
      wait_idle();
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/ppse_pkg.sv
hw/rtl/ppse_front.sv
hw/rtl/ppse_back.sv
hw/rtl/piecewise_polynomial_spline_eval.sv
tb/sv/tb_piecewise_polynomial_spline_eval.sv
